### rtl/core/sle_pkg.sv
// Shared types and constants for the sprite line evaluator.
package sle_pkg;

    localparam int unsigned ENTRY_IDX_W = 6;
    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned SCANLINE_W  = 9;
    localparam int unsigned ROW_W       = 5;
    localparam int unsigned COUNT_W     = 7;
    localparam int unsigned ENTRY_W     = 3 * BYTE_W;
    localparam int unsigned CFG_IDX_W   = 3;
    localparam int unsigned CFG_DATA_W  = 8;
    localparam int unsigned DIFF_W      = 10;

    localparam logic       MODE_WRITE = 1'b0;
    localparam logic       MODE_EVAL  = 1'b1;

    localparam logic [BYTE_W-1:0] END_MARK      = 8'hD0;
    localparam logic [BYTE_W-1:0] Y_WRAP_START  = 8'd240;
    localparam logic [BYTE_W-1:0] ACTIVE_RESET  = 8'd192;
    localparam logic [5:0]        BASE_HEIGHT   = 6'd8;

    localparam logic [CFG_IDX_W-1:0] CFG_EXTENDED = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TALL     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ZOOM     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_NO_LIMIT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_H = 3'd4;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } state_t;

endpackage

### rtl/core/sle_in_if.sv
// Input channel of the sprite line evaluator: table writes and line evaluations.
interface sle_in_if
    import sle_pkg::*;
();
    logic                   valid;
    logic                   ready;
    logic                   mode;
    logic [ENTRY_IDX_W-1:0] entry_index;
    logic [BYTE_W-1:0]      entry_y;
    logic [BYTE_W-1:0]      entry_x;
    logic [BYTE_W-1:0]      entry_pattern;
    logic [SCANLINE_W-1:0]  scanline;
    logic [BYTE_W-1:0]      line_counter;

    modport source (
        output valid, mode, entry_index, entry_y, entry_x, entry_pattern,
               scanline, line_counter,
        input  ready
    );

    modport sink (
        input  valid, mode, entry_index, entry_y, entry_x, entry_pattern,
               scanline, line_counter,
        output ready
    );
endinterface

### rtl/core/sle_out_if.sv
// Sprite line evaluator results: one per found sprite, or one empty if none.
interface sle_out_if
    import sle_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              sprite_valid;
    logic [ROW_W-1:0]  row_offset;
    logic [BYTE_W-1:0] sprite_x;
    logic [BYTE_W-1:0] sprite_pattern;
    logic              overflow;
    logic              last;

    modport source (
        output valid, sprite_valid, row_offset, sprite_x, sprite_pattern,
               overflow, last,
        input  ready
    );

    modport sink (
        input  valid, sprite_valid, row_offset, sprite_x, sprite_pattern,
               overflow, last,
        output ready
    );
endinterface

### rtl/core/sle_ram.sv
// Generic single-write, single-read RAM with registered read data.
module sle_ram #(
    parameter int unsigned WIDTH = 24,
    parameter int unsigned DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

### rtl/core/sprite_line_evaluator.sv
// Sprite line evaluator top level: sprite table, line scan and result output.
//
// in_ch carries two kinds of transaction. A write (mode 0) stores Y, X and
// pattern bytes at entry_index; indexes at or above TABLE_ENTRIES are
// dropped. An evaluate (mode 1) scans the table from entry 0 against
// line_counter and returns one out_ch transaction per sprite that covers the
// line (up to LINE_LIMIT unless no-limit mode is set), the final one marked
// last and carrying overflow. An empty line returns a single transaction
// with sprite_valid low. The table sits in one RAM with a single read port,
// read one entry per cycle while the scan is not frozen by a stalled out_ch.
// The first result appears once the second hit or the end of the scan is
// seen; in_ch is ready again as soon as the final result is in the output
// register. A stalled out_ch freezes the scan only when a hit must pass on
// the pending result; nothing is dropped. cfg_we/cfg_index/cfg_data write
// the mode registers; the user must do so only while the block is idle,
// which the block itself does not enforce. Reset clears control state and
// mode registers, not table contents, which stay undefined until written.
module sprite_line_evaluator
    import sle_pkg::*;
#(
    parameter int unsigned TABLE_ENTRIES = 64,
    parameter int unsigned LINE_LIMIT    = 8
) (
    input  logic                  clk,
    input  logic                  rst_n,
    sle_in_if.sink                in_ch,
    sle_out_if.source             out_ch,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);
    localparam int unsigned AW = $clog2(TABLE_ENTRIES);
    localparam logic [AW-1:0]      LAST_IDX  = AW'(TABLE_ENTRIES - 1);
    localparam logic [COUNT_W-1:0] LIMIT_CNT = COUNT_W'(LINE_LIMIT);
    localparam logic [COUNT_W-1:0] DEPTH_CNT = COUNT_W'(TABLE_ENTRIES);

    state_t state_reg, state_next;

    logic              cfg_ext_reg, cfg_tall_reg, cfg_zoom_reg, cfg_nolim_reg;
    logic [BYTE_W-1:0] cfg_active_reg;

    logic [AW-1:0]         cur_idx_reg, cur_idx_next;
    logic [COUNT_W-1:0]    count_reg, count_next;
    logic [COUNT_W-1:0]    found_count_reg, found_count_next;
    logic                  ovf_reg, ovf_next;
    logic [SCANLINE_W-1:0] scan_reg, scan_next;
    logic [BYTE_W-1:0]     vc_reg, vc_next;

    logic              pend_valid_reg, pend_valid_next;
    logic [ROW_W-1:0]  pend_row_reg, pend_row_next;
    logic [BYTE_W-1:0] pend_x_reg, pend_x_next;
    logic [BYTE_W-1:0] pend_pat_reg, pend_pat_next;

    logic              out_valid_reg, out_valid_next;
    logic              out_sv_reg, out_sv_next;
    logic [ROW_W-1:0]  out_row_reg, out_row_next;
    logic [BYTE_W-1:0] out_x_reg, out_x_next;
    logic [BYTE_W-1:0] out_pat_reg, out_pat_next;
    logic              out_ovf_reg, out_ovf_next;
    logic              out_last_reg, out_last_next;

    logic               ram_we, ram_re;
    logic [AW-1:0]      ram_raddr;
    logic [ENTRY_W-1:0] ram_rdata;

    logic [BYTE_W-1:0]        ent_y, ent_x, ent_pat;
    logic signed [DIFF_W-1:0] ypos, diff;
    logic [5:0]               height;
    logic                     end_mark, hit, lim_hit, stop_limit, out_free;

    sle_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (in_ch.entry_index[AW-1:0]),
        .wdata ({in_ch.entry_y, in_ch.entry_x, in_ch.entry_pattern}),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign ram_we = in_ch.valid && in_ch.ready && (in_ch.mode == MODE_WRITE)
                    && ({1'b0, in_ch.entry_index} < DEPTH_CNT);

    // Entry evaluation on the RAM read data
    assign {ent_y, ent_x, ent_pat} = ram_rdata;
    assign height   = BASE_HEIGHT << ({1'b0, cfg_tall_reg} + {1'b0, cfg_zoom_reg});
    assign end_mark = !cfg_ext_reg && (ent_y == END_MARK);
    assign ypos     = (ent_y >= Y_WRAP_START)
                      ? $signed({2'b00, ent_y}) - 10'sd255
                      : $signed({2'b00, ent_y}) + 10'sd1;
    assign diff     = $signed({2'b00, vc_reg}) - ypos;
    assign hit      = !diff[DIFF_W-1] && (diff < $signed({4'b0000, height}));
    assign lim_hit  = hit && (count_reg == LIMIT_CNT);
    assign stop_limit = lim_hit && !cfg_nolim_reg;
    assign out_free = !out_valid_reg || out_ch.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_ext_reg    <= 1'b0;
            cfg_tall_reg   <= 1'b0;
            cfg_zoom_reg   <= 1'b0;
            cfg_nolim_reg  <= 1'b0;
            cfg_active_reg <= ACTIVE_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_EXTENDED: cfg_ext_reg    <= cfg_data[0];
                CFG_TALL:     cfg_tall_reg   <= cfg_data[0];
                CFG_ZOOM:     cfg_zoom_reg   <= cfg_data[0];
                CFG_NO_LIMIT: cfg_nolim_reg  <= cfg_data[0];
                CFG_ACTIVE_H: cfg_active_reg <= cfg_data;
                default:      ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            count_reg       <= '0;
            found_count_reg <= '0;
            ovf_reg         <= 1'b0;
            pend_valid_reg  <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            count_reg       <= count_next;
            found_count_reg <= found_count_next;
            ovf_reg         <= ovf_next;
            pend_valid_reg  <= pend_valid_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_idx_reg  <= cur_idx_next;
        scan_reg     <= scan_next;
        vc_reg       <= vc_next;
        pend_row_reg <= pend_row_next;
        pend_x_reg   <= pend_x_next;
        pend_pat_reg <= pend_pat_next;
        out_sv_reg   <= out_sv_next;
        out_row_reg  <= out_row_next;
        out_x_reg    <= out_x_next;
        out_pat_reg  <= out_pat_next;
        out_ovf_reg  <= out_ovf_next;
        out_last_reg <= out_last_next;
    end

    always_comb
    begin
        state_next       = state_reg;
        cur_idx_next     = cur_idx_reg;
        count_next       = count_reg;
        found_count_next = found_count_reg;
        ovf_next         = ovf_reg;
        scan_next        = scan_reg;
        vc_next          = vc_reg;
        pend_valid_next  = pend_valid_reg;
        pend_row_next    = pend_row_reg;
        pend_x_next      = pend_x_reg;
        pend_pat_next    = pend_pat_reg;
        out_valid_next   = out_valid_reg && !out_ch.ready;
        out_sv_next      = out_sv_reg;
        out_row_next     = out_row_reg;
        out_x_next       = out_x_reg;
        out_pat_next     = out_pat_reg;
        out_ovf_next     = out_ovf_reg;
        out_last_next    = out_last_reg;
        in_ch.ready      = 1'b0;
        ram_re           = 1'b0;
        ram_raddr        = cur_idx_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                in_ch.ready = 1'b1;
                if (in_ch.valid && (in_ch.mode == MODE_EVAL))
                begin
                    scan_next       = in_ch.scanline;
                    vc_next         = in_ch.line_counter;
                    cur_idx_next    = '0;
                    count_next      = '0;
                    ovf_next        = 1'b0;
                    pend_valid_next = 1'b0;
                    ram_re          = 1'b1;
                    ram_raddr       = '0;
                    state_next      = ST_SCAN;
                end
            end

            ST_SCAN:
            begin
                if (end_mark)
                begin
                    state_next = ST_DONE;
                end
                else if (!(hit && !stop_limit && pend_valid_reg && !out_free))
                begin
                    if (lim_hit && (scan_reg < {1'b0, cfg_active_reg}))
                    begin
                        ovf_next = 1'b1;
                    end
                    if (stop_limit)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        if (hit)
                        begin
                            if (pend_valid_reg)
                            begin
                                out_valid_next = 1'b1;
                                out_sv_next    = 1'b1;
                                out_row_next   = pend_row_reg;
                                out_x_next     = pend_x_reg;
                                out_pat_next   = pend_pat_reg;
                                out_ovf_next   = 1'b0;
                                out_last_next  = 1'b0;
                            end
                            pend_valid_next = 1'b1;
                            pend_row_next   = diff[ROW_W-1:0];
                            pend_x_next     = ent_x;
                            pend_pat_next   = ent_pat;
                            count_next      = count_reg + COUNT_W'(1);
                        end
                        if (cur_idx_reg == LAST_IDX)
                        begin
                            state_next = ST_DONE;
                        end
                        else
                        begin
                            cur_idx_next = cur_idx_reg + AW'(1);
                            ram_re       = 1'b1;
                            ram_raddr    = cur_idx_reg + AW'(1);
                        end
                    end
                end
            end

            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next   = 1'b1;
                    out_last_next    = 1'b1;
                    out_sv_next      = pend_valid_reg;
                    out_row_next     = pend_valid_reg ? pend_row_reg : '0;
                    out_x_next       = pend_valid_reg ? pend_x_reg : '0;
                    out_pat_next     = pend_valid_reg ? pend_pat_reg : '0;
                    out_ovf_next     = pend_valid_reg && ovf_reg;
                    found_count_next = count_reg;
                    pend_valid_next  = 1'b0;
                    state_next       = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_ch.valid          = out_valid_reg;
    assign out_ch.sprite_valid   = out_sv_reg;
    assign out_ch.row_offset     = out_row_reg;
    assign out_ch.sprite_x       = out_x_reg;
    assign out_ch.sprite_pattern = out_pat_reg;
    assign out_ch.overflow       = out_ovf_reg;
    assign out_ch.last           = out_last_reg;

    a_empty_is_final: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && !out_ch.sprite_valid |-> out_ch.last && !out_ch.overflow)
        else $error("empty result not final or flags overflow");

    a_ovf_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.overflow |-> out_ch.last)
        else $error("overflow on a non-final result");

    a_found_bound: assert property (@(posedge clk) disable iff (!rst_n)
        found_count_reg <= DEPTH_CNT)
        else $error("found count beyond table depth");

    a_limit_held: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) && !cfg_nolim_reg |-> count_reg <= LIMIT_CNT)
        else $error("hit count passed the line limit");

    a_done_after_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) && end_mark |=> state_reg == ST_DONE)
        else $error("end marker did not end the scan");
endmodule
